>>> sv/trsr_pkg.sv
// ----------------------------------------------------------------------------
// trsr_pkg: shared definitions for the triangle slice range block
// Field widths, pipeline widths, register indexes and the records that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package trsr_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_SLICES  = 1024;
	localparam int CNT_W       = 11;
	localparam int COORD_W     = 32;
	localparam int DIST_W      = 32;
	localparam int NUM_VERT    = 3;
	localparam int NUM_AXIS    = 3;
	localparam int IN_W        = NUM_VERT * NUM_AXIS * COORD_W;

	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = DIFF_W + COORD_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int OFF_W       = CNT_W + 1 + COORD_W;
	localparam int NUM_W       = OFF_W + 1;
	// The slice numerator stays below 2^42 in magnitude.
	localparam int ABS_W       = 43;
	localparam int DEN_W       = COORD_W + 1;
	localparam int IDX_W       = CNT_W;
	localparam int QUO_W       = FRAC_BITS + IDX_W;
	localparam int BOUND_W     = IDX_W + 2;

	localparam int OUT_IDX_W   = 10;
	localparam int OUT_W       = 88;
	localparam int OUT_PAD     = OUT_W - 2 * OUT_IDX_W - 2 * DIST_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam int REG_IDX_W   = 3;
	localparam int CFG_W       = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_NORMAL_X,
		REG_NORMAL_Y,
		REG_NORMAL_Z,
		REG_SLICE_COUNT,
		REG_SLICE_SPACING
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_MISS,
		CLS_ALL,
		CLS_DIV
	} cls_t;

	typedef struct packed {
		logic [NUM_AXIS-1:0][COORD_W-1:0] origin;
		logic [NUM_AXIS-1:0][COORD_W-1:0] normal;
		logic [CNT_W-1:0]                 cnt;
		logic [COORD_W-1:0]               spacing;
	} cfg_t;

	typedef struct packed {
		logic [DIST_W-1:0] mn;
		logic [DIST_W-1:0] mx;
		cls_t              cls;
		logic [ABS_W-1:0]  amin;
		logic              nmin;
		logic [ABS_W-1:0]  amax;
		logic              nmax;
	} item_t;

endpackage

>>> sv/triangle_slice_range_top.sv
// ----------------------------------------------------------------------------
// triangle_slice_range_top: bins triangles into a stack of parallel slices
// Each triangle enters on the slave stream as nine Q16.16 coordinates. The
// block measures the vertices against the configured plane and returns the
// run of slices that the triangle spans together with its distance range.
//
// Usage:
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// item is in flight. One result item leaves on the master stream for every
// triangle. With no stall the result becomes valid after acceptance once
// the item has passed the distance pipeline, the queue, the divider (a
// set-up stage and one quotient bit per cycle) and the result registers.
// One triangle is accepted every cycle while s_tready is high.
// When m_tready is low the back end holds, the four-entry queue fills and
// s_tready falls while the queue is full and the last front stage holds an item.
// Reset clears all pipeline valid bits and the queue, and returns every
// configuration register to its reset value.
// ----------------------------------------------------------------------------
module triangle_slice_range_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [trsr_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [trsr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: ax, ay, az, bx, by, bz, cx, cy, cz (32 bits each)
	input  logic [trsr_pkg::IN_W-1:0]      s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: first_slice, last_slice, min_distance, max_distance, zero fill
	output logic [trsr_pkg::OUT_W-1:0]     m_tdata,
	// m_tuser: hit
	output logic                           m_tuser
);
	import trsr_pkg::*;

	logic [NUM_AXIS-1:0][COORD_W-1:0] origin_q;
	logic [NUM_AXIS-1:0][COORD_W-1:0] normal_q;
	logic [CNT_W-1:0]                 slice_count_q;
	logic [COORD_W-1:0]               slice_spacing_q;
	cfg_t                             cfg;

	logic  q_full, q_empty, q_push, q_pop;
	item_t q_in, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q        <= '0;
			normal_q        <= {COORD_W'(1 << FRAC_BITS), {(2*COORD_W){1'b0}}};
			slice_count_q   <= '0;
			slice_spacing_q <= COORD_W'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X:      origin_q[0]     <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y:      origin_q[1]     <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Z:      origin_q[2]     <= cfg_data[COORD_W-1:0];
				REG_NORMAL_X:      normal_q[0]     <= cfg_data[COORD_W-1:0];
				REG_NORMAL_Y:      normal_q[1]     <= cfg_data[COORD_W-1:0];
				REG_NORMAL_Z:      normal_q[2]     <= cfg_data[COORD_W-1:0];
				REG_SLICE_COUNT:   slice_count_q   <= cfg_data[CNT_W-1:0];
				REG_SLICE_SPACING: slice_spacing_q <= cfg_data[COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.origin  = origin_q;
		cfg.normal  = normal_q;
		cfg.cnt     = (slice_count_q > CNT_W'(MAX_SLICES)) ? CNT_W'(MAX_SLICES) : slice_count_q;
		cfg.spacing = slice_spacing_q;
	end

	trsr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (q_push),
		.item     (q_in)
	);

	trsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	trsr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.head     (q_head),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTHESIS
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[19:10] >= m_tdata[9:0]))
		else $error("hit item with first slice above last slice");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[19:0] == 20'd0))
		else $error("missed item carries a slice run");

	a_dist_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[51:20]) <= $signed(m_tdata[83:52])))
		else $error("minimum distance above maximum distance");
`endif

endmodule

>>> sv/trsr_front.sv
// ----------------------------------------------------------------------------
// trsr_front: distance pipeline and item classification
// Forms the three plane distances, their minimum and maximum, and the slice
// numerators, then hands each classified item to the queue.
// ----------------------------------------------------------------------------
module trsr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  trsr_pkg::cfg_t            cfg,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [trsr_pkg::IN_W-1:0] s_tdata,
	input  logic                      q_full,
	output logic                      push,
	output trsr_pkg::item_t           item
);
	import trsr_pkg::*;

	logic en;
	logic acc;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [DIFF_W-1:0] d_s1   [NUM_VERT*NUM_AXIS];
	logic signed [PROD_W-1:0] p_s2   [NUM_VERT*NUM_AXIS];
	logic signed [SUM_W-1:0]  sum_s3 [NUM_VERT];
	logic signed [DIST_W-1:0] dist_s4 [NUM_VERT];
	logic signed [DIST_W-1:0] mn_s5, mx_s5;
	logic signed [OFF_W-1:0]  off_s5;
	item_t                    item_s6;

	logic signed [DIST_W-1:0] dist_c [NUM_VERT];
	logic signed [DIST_W-1:0] mn_c, mx_c;
	logic [CNT_W:0]           cm1_u;
	logic signed [NUM_W-1:0]  num_mn, num_mx;
	logic                     near_zero;
	item_t                    item_c;

	assign en       = !v_s6 || !q_full;
	assign s_tready = en;
	assign acc      = s_tvalid && en;
	assign push     = v_s6 && !q_full;
	assign item     = item_s6;

	assign cm1_u = {1'b0, cfg.cnt} - {{CNT_W{1'b0}}, 1'b1};

	always_comb begin
		for (int i = 0; i < NUM_VERT; i++) begin
			if ((&sum_s3[i][SUM_W-1:FRAC_BITS+DIST_W-1]) ||
			    !(|sum_s3[i][SUM_W-1:FRAC_BITS+DIST_W-1])) begin
				dist_c[i] = sum_s3[i][FRAC_BITS+DIST_W-1:FRAC_BITS];
			end else if (sum_s3[i][SUM_W-1]) begin
				dist_c[i] = {1'b1, {(DIST_W-1){1'b0}}};
			end else begin
				dist_c[i] = {1'b0, {(DIST_W-1){1'b1}}};
			end
		end
	end

	always_comb begin
		mn_c = dist_s4[0];
		mx_c = dist_s4[0];
		for (int i = 1; i < NUM_VERT; i++) begin
			if (dist_s4[i] < mn_c) mn_c = dist_s4[i];
			if (dist_s4[i] > mx_c) mx_c = dist_s4[i];
		end
	end

	always_comb begin
		num_mn    = (NUM_W'(mn_s5) <<< 1) + NUM_W'(off_s5);
		num_mx    = (NUM_W'(mx_s5) <<< 1) + NUM_W'(off_s5);
		near_zero = (&cfg.spacing) || !(|cfg.spacing[COORD_W-1:1]);
		item_c.mn   = mn_s5;
		item_c.mx   = mx_s5;
		item_c.amin = num_mn[NUM_W-1] ? ABS_W'(-num_mn) : ABS_W'(num_mn);
		item_c.nmin = num_mn[NUM_W-1] ^ cfg.spacing[COORD_W-1];
		item_c.amax = num_mx[NUM_W-1] ? ABS_W'(-num_mx) : ABS_W'(num_mx);
		item_c.nmax = num_mx[NUM_W-1] ^ cfg.spacing[COORD_W-1];
		if (cfg.cnt == '0) begin
			item_c.cls = CLS_MISS;
		end else if (near_zero) begin
			if (mn_s5 > DIST_W'(1) || mx_s5 < -DIST_W'(1)) begin
				item_c.cls = CLS_MISS;
			end else begin
				item_c.cls = CLS_ALL;
			end
		end else begin
			item_c.cls = CLS_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_VERT; i++) begin
				for (int a = 0; a < NUM_AXIS; a++) begin
					d_s1[i*NUM_AXIS+a] <=
						DIFF_W'($signed(s_tdata[(i*NUM_AXIS+a)*COORD_W +: COORD_W])) -
						DIFF_W'($signed(cfg.origin[a]));
					p_s2[i*NUM_AXIS+a] <=
						PROD_W'(d_s1[i*NUM_AXIS+a]) * PROD_W'($signed(cfg.normal[a]));
				end
				sum_s3[i]  <= SUM_W'(p_s2[i*NUM_AXIS]) + SUM_W'(p_s2[i*NUM_AXIS+1]) +
				              SUM_W'(p_s2[i*NUM_AXIS+2]);
				dist_s4[i] <= dist_c[i];
			end
			mn_s5   <= mn_c;
			mx_s5   <= mx_c;
			off_s5  <= OFF_W'($signed(cm1_u)) * OFF_W'($signed(cfg.spacing));
			item_s6 <= item_c;
		end
	end

endmodule

>>> sv/trsr_queue.sv
// ----------------------------------------------------------------------------
// trsr_queue: short item queue between front end and back end
// A small register file with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module trsr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  trsr_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output trsr_pkg::item_t head
);
	import trsr_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + QPTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (!do_push && do_pop) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_item;
	end

endmodule

>>> sv/trsr_back.sv
// ----------------------------------------------------------------------------
// trsr_back: slice index divider and result stage
// Two restoring dividers, one quotient bit per stage, turn the slice
// numerators into the first and last slice, which are clamped to the stack.
// ----------------------------------------------------------------------------
module trsr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  trsr_pkg::cfg_t             cfg,
	input  logic                       q_empty,
	input  trsr_pkg::item_t            head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [trsr_pkg::OUT_W-1:0] m_tdata,
	output logic                       m_tuser
);
	import trsr_pkg::*;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [IDX_W-1:0] lo;
		logic             neg;
		logic             ovf;
	} div_lane_t;

	typedef struct packed {
		logic [DIST_W-1:0] mn;
		logic [DIST_W-1:0] mx;
		cls_t              cls;
		div_lane_t         lmin;
		div_lane_t         lmax;
	} bstage_t;

	typedef struct packed {
		logic [DIST_W-1:0] mn;
		logic [DIST_W-1:0] mx;
		cls_t              cls;
		logic [QUO_W:0]    qmin;
		logic              omin;
		logic              nmin;
		logic [QUO_W:0]    qmax;
		logic              omax;
		logic              nmax;
	} fin_t;

	localparam logic signed [BOUND_W-1:0] BOUND_HI = BOUND_W'((1 << IDX_W) - 1);
	localparam logic signed [BOUND_W-1:0] BOUND_LO = BOUND_W'(-(1 << IDX_W));

	function automatic div_lane_t lane_init(logic [ABS_W-1:0] a, logic neg,
	                                        logic [DEN_W-1:0] den);
		div_lane_t r;
		r.rem = DEN_W'(a[ABS_W-1:IDX_W]);
		r.quo = '0;
		r.lo  = a[IDX_W-1:0];
		r.neg = neg;
		r.ovf = ({1'b0, a} >= {den, {IDX_W{1'b0}}});
		return r;
	endfunction

	function automatic div_lane_t div_step(div_lane_t a, logic [DEN_W-1:0] den, logic xbit,
	                                       logic [QUO_W-1:0] qmask);
		logic [DEN_W:0] t;
		div_lane_t      r;
		t = {a.rem, xbit};
		r = a;
		if (t >= {1'b0, den}) begin
			r.rem = DEN_W'(t - {1'b0, den});
			r.quo = a.quo | qmask;
		end else begin
			r.rem = t[DEN_W-1:0];
		end
		return r;
	endfunction

	// Floor quotient with the fraction in the low bits; negative quotients
	// round down when a remainder is left.
	function automatic logic [QUO_W:0] q_fix(div_lane_t a);
		logic [QUO_W:0] q;
		if (a.neg) q = ~{1'b0, a.quo} + (QUO_W+1)'(a.rem == '0);
		else q = {1'b0, a.quo};
		return q;
	endfunction

	function automatic logic signed [BOUND_W-1:0] bound_idx(logic [QUO_W:0] q, logic ovf,
	                                                        logic neg, logic up);
		logic signed [IDX_W:0]        qi;
		logic [FRAC_BITS-1:0]         frac;
		logic                         inc;
		logic signed [BOUND_W-1:0]    r;
		qi   = $signed(q[QUO_W:FRAC_BITS]);
		frac = q[FRAC_BITS-1:0];
		inc  = up ? (frac == '1) : (frac > FRAC_BITS'(1));
		r    = BOUND_W'(qi) + {{(BOUND_W-1){1'b0}}, inc};
		if (ovf) r = neg ? BOUND_LO : BOUND_HI;
		return r;
	endfunction

	logic                      en;
	logic [DEN_W-1:0]          den;
	logic [DEN_W-1:0]          two_s;
	logic                      dv_v [QUO_W+1];
	bstage_t                   dv_s [QUO_W+1];
	logic                      fin_v_s;
	fin_t                      fin_s;
	logic                      out_v_q;
	logic                      out_hit_q;
	logic [OUT_W-1:0]          out_data_q;

	logic signed [BOUND_W-1:0] cm1;
	logic signed [BOUND_W-1:0] fb, lb, fc, lc;
	logic                      o_hit;
	logic [OUT_IDX_W-1:0]      o_first, o_last;

	assign en       = !out_v_q || m_tready;
	assign pop      = en && !q_empty;
	assign two_s    = {cfg.spacing, 1'b0};
	assign den      = cfg.spacing[COORD_W-1] ? (DEN_W'(0) - two_s) : two_s;
	assign cm1      = $signed(BOUND_W'(cfg.cnt) - BOUND_W'(1));
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].mn   <= head.mn;
			dv_s[0].mx   <= head.mx;
			dv_s[0].cls  <= head.cls;
			dv_s[0].lmin <= lane_init(head.amin, head.nmin, den);
			dv_s[0].lmax <= lane_init(head.amax, head.nmax, den);
		end
	end

	// Stage j + 1 settles quotient bit QUO_W - 1 - j of both dividers.
	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int K = QUO_W - 1 - j;
		logic xmin, xmax;

		if (K >= FRAC_BITS) begin : g_bit
			assign xmin = dv_s[j].lmin.lo[K-FRAC_BITS];
			assign xmax = dv_s[j].lmax.lo[K-FRAC_BITS];
		end else begin : g_zero
			assign xmin = 1'b0;
			assign xmax = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j+1].mn   <= dv_s[j].mn;
				dv_s[j+1].mx   <= dv_s[j].mx;
				dv_s[j+1].cls  <= dv_s[j].cls;
				dv_s[j+1].lmin <= div_step(dv_s[j].lmin, den, xmin, QUO_W'(1) << K);
				dv_s[j+1].lmax <= div_step(dv_s[j].lmax, den, xmax, QUO_W'(1) << K);
			end
		end
	end

	always_comb begin
		fb = bound_idx(fin_s.qmin, fin_s.omin, fin_s.nmin, 1'b0);
		lb = bound_idx(fin_s.qmax, fin_s.omax, fin_s.nmax, 1'b1);
		fc = fb[BOUND_W-1] ? '0 : fb;
		lc = (lb > cm1) ? cm1 : lb;
		o_hit   = 1'b0;
		o_first = '0;
		o_last  = '0;
		case (fin_s.cls)
			CLS_DIV: begin
				if (fc <= lc) begin
					o_hit   = 1'b1;
					o_first = fc[OUT_IDX_W-1:0];
					o_last  = lc[OUT_IDX_W-1:0];
				end
			end
			CLS_ALL: begin
				o_hit  = 1'b1;
				o_last = cm1[OUT_IDX_W-1:0];
			end
			default: begin
				o_hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			fin_v_s <= dv_v[QUO_W];
			out_v_q <= fin_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s.mn   <= dv_s[QUO_W].mn;
			fin_s.mx   <= dv_s[QUO_W].mx;
			fin_s.cls  <= dv_s[QUO_W].cls;
			fin_s.qmin <= q_fix(dv_s[QUO_W].lmin);
			fin_s.omin <= dv_s[QUO_W].lmin.ovf;
			fin_s.nmin <= dv_s[QUO_W].lmin.neg;
			fin_s.qmax <= q_fix(dv_s[QUO_W].lmax);
			fin_s.omax <= dv_s[QUO_W].lmax.ovf;
			fin_s.nmax <= dv_s[QUO_W].lmax.neg;
			out_hit_q  <= o_hit;
			out_data_q <= {{OUT_PAD{1'b0}}, fin_s.mx, fin_s.mn, o_last, o_first};
		end
	end

endmodule
